>>> rtl/core/otet_pkg.sv
package otet_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_CREATE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam int unsigned TagW  = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DelW  = 16;
  localparam int unsigned TickW = 8;

  localparam logic [TickW-1:0] TickReset = 8'd2;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [TagW-1:0] event_tag;
    logic [DelW-1:0] delay_ms;
  } otet_req_t;

  typedef struct packed {
    logic            status;
    logic            fired;
    logic [TagW-1:0] fired_tag;
  } otet_rsp_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] deadline;
  } otet_slot_t;

  // Shared control for every cell of the ring.
  typedef struct packed {
    logic shift;
    logic clr;
  } otet_cell_ctrl_t;

endpackage

>>> rtl/core/otet_cell.sv
module otet_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  otet_pkg::otet_cell_ctrl_t ctrl_i,
  input  otet_pkg::otet_slot_t      slot_i,
  output otet_pkg::otet_slot_t      slot_o
);
  import otet_pkg::*;

  otet_slot_t slot_q, slot_d;

  // Clear wins over shift; otherwise take the neighbor's slot on a shift.
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clr) begin
      slot_d = '0;
    end else if (ctrl_i.shift) begin
      slot_d = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

>>> rtl/core/oneshot_timer_event_table.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   otet_req_t  (req_type, event_tag, delay_ms)
// out       output     out_valid_o / out_stall_i otet_rsp_t  (status, fired, fired_tag)
// cfg       input      cfg_we_i                  cfg_wdata_i (tick_ms)
//
// Create and tick items are accepted in ST_IDLE, rotate the slot ring once past the head
// cell in ST_SCAN, and load the output register from ST_RESP.
// Clear, null-tag create and unused request codes skip ST_SCAN and go from ST_IDLE to ST_RESP.
// Reset empties every slot, zeroes the time counter and sets tick_ms to 2.
// A stalled result sits in the output register; the next item is still accepted and
// its result waits in the response state until the output register frees up.
module oneshot_timer_event_table #(
  parameter int unsigned SLOTS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  otet_pkg::otet_req_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output otet_pkg::otet_rsp_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [otet_pkg::TickW-1:0]    cfg_wdata_i
);
  import otet_pkg::*;

  localparam int unsigned CntW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  step_q, step_d;
  logic             found_q, found_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [TickW-1:0] tick_q;
  otet_req_t        req_q, req_d;
  otet_rsp_t        rsp_q, rsp_d;
  logic             out_valid_q, out_valid_d;
  otet_rsp_t        out_q, out_d;

  // The slot ring. Cell k takes cell k+1 on a shift; the last cell takes the
  // head (cell 0) after the head has been inspected and possibly rewritten.
  // One full rotation visits slots in index order and restores their places.
  otet_cell_ctrl_t  cell_ctrl;
  otet_slot_t       cell_q [SLOTS];
  otet_slot_t       head_next;
  logic             hit;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    otet_slot_t nb;
    if (k == SLOTS - 1) begin : g_last
      assign nb = head_next;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    otet_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .slot_i (nb),
      .slot_o (cell_q[k])
    );
  end

  wire accept = in_valid_i && (state_q == ST_IDLE);
  wire out_free = !out_valid_q || !out_stall_i;

  // Head cell inspection: only the first match of a scan acts.
  always_comb begin
    head_next = cell_q[0];
    hit       = 1'b0;
    if (state_q == ST_SCAN && !found_q) begin
      case (req_q.req_type)
        REQ_CREATE: begin
          if (cell_q[0].tag == '0) begin
            hit                = 1'b1;
            head_next.tag      = req_q.event_tag;
            head_next.deadline = time_q + TimeW'(req_q.delay_ms);
          end
        end
        REQ_TICK: begin
          if (cell_q[0].tag != '0 && time_q > cell_q[0].deadline) begin
            hit       = 1'b1;
            head_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    found_d     = found_q;
    time_d      = time_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cell_ctrl   = '0;

    // Drop the held result once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          rsp_d   = '0;
          step_d  = '0;
          found_d = 1'b0;
          case (in_data_i.req_type)
            REQ_CLEAR: begin
              cell_ctrl.clr = 1'b1;
              time_d        = '0;
              state_d       = ST_RESP;
            end
            REQ_CREATE: begin
              if (in_data_i.event_tag == '0) begin
                rsp_d.status = 1'b1;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            REQ_TICK: begin
              // Advance time before the expiry scan.
              time_d  = time_q + TimeW'(tick_q);
              state_d = ST_SCAN;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        if (hit) begin
          found_d = 1'b1;
          if (req_q.req_type == REQ_TICK) begin
            rsp_d.fired     = 1'b1;
            rsp_d.fired_tag = cell_q[0].tag;
          end
        end
        if (step_q == LastStep) begin
          if (req_q.req_type == REQ_CREATE) begin
            rsp_d.status = !(found_q || hit);
          end
          state_d = ST_RESP;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = rsp_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      found_q     <= 1'b0;
      time_q      <= '0;
      tick_q      <= TickReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A fired flag and a non-zero tag always travel together.
  a_fired_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fired == (out_data_o.fired_tag != '0)))
    else $error("fired flag and fired tag disagree");

  // An error result never reports an expiry.
  a_err_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> !out_data_o.fired)
    else $error("error result with fired event");

  // An accepted item blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // The scan step never runs past the last slot.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (step_q <= LastStep))
    else $error("scan step out of range");

endmodule

>>> tb/testbench.sv
package timer_table_check_pkg;
  import otet_pkg::*;

  class event_table_scoreboard #(int unsigned SLOTS = 5);
    logic [TickW-1:0] tick_ms;
    logic [TimeW-1:0] now_ms;
    logic [TagW-1:0]  tags[SLOTS];
    logic [TimeW-1:0] deadlines[SLOTS];
    otet_rsp_t        pending_responses[$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    function new();
      tick_ms = TickReset;
      clear_table();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void clear_table();
      now_ms = '0;
      for (int k = 0; k < SLOTS; k++) begin
        tags[k] = '0;
        deadlines[k] = '0;
      end
    endfunction

    function void set_tick(logic [TickW-1:0] value);
      tick_ms = value;
    endfunction

    function int unsigned pending_count();
      return pending_responses.size();
    endfunction

    // Advance the table by one request and queue the response it must produce.
    function void note_request(otet_req_t req);
      otet_rsp_t rsp;
      int        free_idx;
      rsp = '0;
      free_idx = -1;
      case (req.req_type)
        REQ_CLEAR: begin
          clear_table();
        end
        REQ_CREATE: begin
          for (int k = 0; k < SLOTS; k++) begin
            if (tags[k] == '0 && free_idx < 0) free_idx = k;
          end
          if (req.event_tag == '0 || free_idx < 0) begin
            rsp.status = 1'b1;
          end else begin
            tags[free_idx] = req.event_tag;
            deadlines[free_idx] = now_ms + req.delay_ms;
          end
        end
        REQ_TICK: begin
          now_ms = now_ms + tick_ms;
          for (int k = 0; k < SLOTS; k++) begin
            if (!rsp.fired && tags[k] != '0 && now_ms > deadlines[k]) begin
              rsp.fired = 1'b1;
              rsp.fired_tag = tags[k];
              tags[k] = '0;
              deadlines[k] = '0;
            end
          end
        end
        default: begin
        end
      endcase
      pending_responses.push_back(rsp);
    endfunction

    task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got_v, want_v);
      mismatches++;
    endtask

    task check_response(otet_rsp_t got);
      otet_rsp_t want;
      if (pending_responses.size() == 0) begin
        report_mismatch("unrequested result", got, 0);
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.fired !== want.fired) report_mismatch("fired", got.fired, want.fired);
        if (got.fired_tag !== want.fired_tag) begin
          report_mismatch("fired_tag", got.fired_tag, want.fired_tag);
        end
      end
      results_seen++;
    endtask
  endclass

endpackage

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import otet_pkg::*;
  import timer_table_check_pkg::*;

  localparam int unsigned NumSlots     = 5;
  localparam int unsigned ResetCycles  = 11;
  // Settle wait: covers a scan of every slot and the output load, with margin.
  localparam int unsigned SettleCycles = NumSlots + 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StuckLimit   = 5000;
  localparam int unsigned PhaseItems   = 255;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned IdlePercent  = 21;
  // Request code the block leaves unused; it must be ignored.
  localparam logic [1:0]  ReqUnused    = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  otet_req_t        in_data;
  logic             out_valid;
  logic             out_stall;
  otet_rsp_t        out_data;
  logic             cfg_we;
  logic [TickW-1:0] cfg_wdata;

  event_table_scoreboard #(.SLOTS(NumSlots)) sb;

  // Tick step the stimulus shapes its delays around.
  logic [TickW-1:0] cur_tick;
  bit               quiet_stretch = 1'b0;
  bit               hold_off_req = 1'b0;
  int unsigned      stuck_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  oneshot_timer_event_table #(
    .SLOTS(NumSlots)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Sample both channels at the rising edge. Check the outgoing item first: it can never
  // belong to the request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: stall at random, hold off for a long stretch on request, and never stall
  // while the quiet stretch runs.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else if (quiet_stretch) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePercent);
      end
    end
  end

  function automatic otet_req_t make_req(logic [1:0] kind, logic [TagW-1:0] tag,
                                         logic [DelW-1:0] delay);
    otet_req_t r;
    r.req_type = kind;
    r.event_tag = tag;
    r.delay_ms = delay;
    return r;
  endfunction

  // Mostly creates and ticks so the table fills, fires and overflows; a few clears and
  // ignored codes as noise. Delays scale with the tick step so events do expire.
  function automatic otet_req_t random_item();
    otet_req_t   r;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = 8 * int'(cur_tick) + 2;
    r.event_tag = ($urandom_range(99) < 8) ? '0 : TagW'($urandom_range(255, 1));
    if ($urandom_range(9) == 0) begin
      r.delay_ms = DelW'($urandom());
    end else begin
      r.delay_ms = DelW'($urandom_range(span));
    end
    if (pick < 40) begin
      r.req_type = REQ_CREATE;
    end else if (pick < 88) begin
      r.req_type = REQ_TICK;
    end else if (pick < 93) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = ReqUnused;
    end
    return r;
  endfunction

  // Offer one item, with random idle cycles first; noise rides on the bus while idle.
  task automatic send_item(input otet_req_t item);
    @(negedge clk);
    while (!quiet_stretch && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      in_data <= otet_req_t'($urandom());
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every queued response has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  // Write the tick step while the block is idle; the model follows at once.
  task automatic write_tick(input logic [TickW-1:0] value);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_tick(value);
    cur_tick = value;
  endtask

  initial begin
    otet_req_t        directed[$];
    logic [TickW-1:0] phase_tick;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    cur_tick = TickReset;
    sb = new();
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset tick step of 2.
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));    // tick on an empty table
    directed.push_back(make_req(REQ_CREATE, 8'h00, 16'h0005));  // null tag
    directed.push_back(make_req(REQ_CREATE, 8'hFF, 16'h0000));
    directed.push_back(make_req(REQ_CREATE, 8'h01, 16'hFFFF));
    directed.push_back(make_req(REQ_CREATE, 8'h55, 16'h0001));
    directed.push_back(make_req(REQ_CREATE, 8'hAA, 16'h0003));
    directed.push_back(make_req(REQ_CREATE, 8'h80, 16'h0000));
    directed.push_back(make_req(REQ_CREATE, 8'h7F, 16'h0010));  // table full
    directed.push_back(make_req(ReqUnused, 8'hFF, 16'hFFFF));   // ignored code
    directed.push_back(make_req(REQ_TICK, 8'hFF, 16'hFFFF));    // three due, lowest slot fires
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    directed.push_back(make_req(REQ_CREATE, 8'h33, 16'h0000));  // reuse a freed slot
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    directed.push_back(make_req(REQ_CLEAR, 8'hFF, 16'hFFFF));   // long event dropped
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    directed.push_back(make_req(REQ_CREATE, 8'h01, 16'h0002));
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));    // deadline equals time
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));    // now strictly past
    directed.push_back(make_req(REQ_TICK, 8'h00, 16'h0000));
    foreach (directed[i]) send_item(directed[i]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Hold the reset step for the first phase, then walk the extremes and random steps.
      if (phase != 0) begin
        case (phase)
          1: phase_tick = 8'd255;
          2: phase_tick = 8'd1;
          3: phase_tick = 8'd0;
          default: phase_tick = TickW'($urandom_range(254, 1));
        endcase
        drain_results();
        write_tick(phase_tick);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // Fill the block behind a long receiver hold-off, then pause to drain once.
        if (phase == 1 && n == 60) hold_off_req = 1'b1;
        if (phase == 1 && n == 150) drain_results();
        quiet_stretch = (phase == 2 && n >= 40 && n < 160);
        send_item(random_item());
      end
      quiet_stretch = 1'b0;
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> oneshot_timer_event_table.f
rtl/core/otet_pkg.sv
rtl/core/otet_cell.sv
rtl/core/oneshot_timer_event_table.sv
tb/testbench.sv
